>>> rtl/core/signed_varint_byte_encoder_core_defines.svh
// assertion macros for the signed varint byte encoder
`ifndef SIGNED_VARINT_BYTE_ENCODER_CORE_DEFINES_SVH
`define SIGNED_VARINT_BYTE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SVE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SVE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sve_pkg.sv
// types and constants shared by the signed varint byte encoder
package sve_pkg;

    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int FIRST_W   = 6;
    localparam int DIGIT_W   = 7;

    localparam logic [BYTE_W-1:0] SIGN_BIT  = 8'h40;
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3f;
    localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_block;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_word;
        logic              last_of_block;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              more;
    } t_shift_stat;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/sve_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
interface sve_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/signed_varint_byte_encoder_core.sv
// top level of the signed varint byte encoder
// the first byte of a word is offered in the cycle after its transaction
// throughput: one byte per cycle while o_out.ready is held high, 1 to 10 bytes per word (10 for
//   magnitudes of 2^62 and up), set by the magnitude shift register (6 bits for the first byte, 7 after)
// a new word is taken in the cycle its predecessor's last byte leaves, so words already waiting run gap-free
// reset: synchronous active-low i_rst_n returns the sequencer to idle with no byte pending
`include "signed_varint_byte_encoder_core_defines.svh"

module signed_varint_byte_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sve_stream_if.sink   i_in,
    sve_stream_if.source o_out
);

    sve_pkg::t_state      r_state;
    sve_pkg::t_state      n_state;
    logic                 r_eob;
    sve_pkg::t_shift_ctrl w_ctrl;
    sve_pkg::t_shift_stat w_stat;
    logic                 w_out_fire;
    logic                 w_in_fire;

    sve_digit_shifter u_shifter (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (i_in.data.value),
        .o_stat  (w_stat)
    );

    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sve_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_eob <= i_in.data.end_of_block;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_out.valid = 1'b0;
        i_in.ready  = 1'b0;
        unique case (r_state)
            sve_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = sve_pkg::ST_EMIT;
                end
            end
            sve_pkg::ST_EMIT: begin
                o_out.valid = 1'b1;
                i_in.ready  = o_out.ready && !w_stat.more;
                if (o_out.ready && !w_stat.more && !i_in.valid) begin
                    n_state = sve_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sve_pkg::ST_IDLE;
            end
        endcase
        w_ctrl.load  = w_in_fire;
        w_ctrl.shift = w_out_fire;
    end

    assign o_out.data.out_byte      = w_stat.out_byte;
    assign o_out.data.last_of_word  = !w_stat.more;
    assign o_out.data.last_of_block = !w_stat.more && r_eob;

    `SVE_ASSERT_NXT(a_accept_then_byte, i_clk, i_rst_n, w_in_fire, o_out.valid, "no byte after accepted word")
    `SVE_ASSERT_IMP(a_ready_only_on_last, i_clk, i_rst_n, i_in.ready && (r_state == sve_pkg::ST_EMIT), w_out_fire && o_out.data.last_of_word, "word taken before previous word finished")
    `SVE_ASSERT_NXT(a_cont_then_more, i_clk, i_rst_n, w_out_fire && o_out.data.out_byte[7], o_out.valid, "continuation byte not followed by another byte")

endmodule

>>> rtl/core/sve_digit_shifter.sv
// magnitude shift register that hands out one encoded byte per step
module sve_digit_shifter (
    input  logic                               i_clk,
    input  sve_pkg::t_shift_ctrl               i_ctrl,
    input  logic signed [sve_pkg::VALUE_W-1:0] i_value,
    output sve_pkg::t_shift_stat               o_stat
);

    logic [sve_pkg::VALUE_W-1:0] r_mag;
    logic [sve_pkg::VALUE_W-1:0] n_mag;
    logic                        r_first;
    logic                        r_sign;
    logic [sve_pkg::BYTE_W-1:0]  w_digit;
    logic                        w_more;

    always_comb begin
        n_mag = r_mag;
        if (i_ctrl.load) begin
            if (i_value[sve_pkg::VALUE_W-1]) begin
                n_mag = ~$unsigned(i_value) + {{(sve_pkg::VALUE_W-1){1'b0}}, 1'b1};
            end else begin
                n_mag = $unsigned(i_value);
            end
        end else if (i_ctrl.shift) begin
            if (r_first) begin
                n_mag = r_mag >> sve_pkg::FIRST_W;
            end else begin
                n_mag = r_mag >> sve_pkg::DIGIT_W;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        if (i_ctrl.load) begin
            r_first <= 1'b1;
            r_sign  <= i_value[sve_pkg::VALUE_W-1];
        end else if (i_ctrl.shift) begin
            r_first <= 1'b0;
        end
    end

    always_comb begin
        if (r_first) begin
            w_more  = |r_mag[sve_pkg::VALUE_W-1:sve_pkg::FIRST_W];
            w_digit = (r_sign ? sve_pkg::SIGN_BIT : '0)
                    | (r_mag[sve_pkg::BYTE_W-1:0] & sve_pkg::LOW6_MASK);
        end else begin
            w_more  = |r_mag[sve_pkg::VALUE_W-1:sve_pkg::DIGIT_W];
            w_digit = r_mag[sve_pkg::BYTE_W-1:0] & sve_pkg::LOW7_MASK;
        end
        o_stat.out_byte = w_digit | (w_more ? sve_pkg::CONT_BIT : '0);
        o_stat.more     = w_more;
    end

endmodule
